// ===== src/sspc_pkg.sv =====
// ----------------------------------------------------------------------------
// sspc_pkg
// Shared types and constants of the seven-segment panel composer: the
// classified panel word, segment codes and display limits.
// ----------------------------------------------------------------------------
package sspc_pkg;

  typedef struct packed {
    logic        big_hi;
    logic        big_lo;
    logic        big_neg;
    logic        big_point;
    logic [10:0] big_mag;
    logic        small_hi;
    logic        small_lo;
    logic        small_neg;
    logic [6:0]  small_mag;
    logic        pct;
    logic        bat;
    logic [7:0]  byte2;
  } item_t;

  localparam logic [7:0] SEG_DIGIT [16] = '{
    8'hF5, 8'h05, 8'hD3, 8'h97, 8'h27, 8'hB6, 8'hF6, 8'h15,
    8'hF7, 8'hB7, 8'h77, 8'hE6, 8'hF0, 8'hC7, 8'hF2, 8'h72
  };

  localparam logic signed [15:0] BIG_HI_LIM   = 16'sd19995;
  localparam logic signed [15:0] BIG_LO_LIM   = -16'sd995;
  localparam logic signed [15:0] POINT_HI_LIM = 16'sd1995;
  localparam logic signed [15:0] POINT_LO_LIM = -16'sd95;
  localparam logic signed [15:0] SMALL_HI_LIM = 16'sd99;
  localparam logic signed [15:0] SMALL_LO_LIM = -16'sd9;

  localparam logic [15:0] DIV10_MUL   = 16'd52429;

  localparam logic [1:0] UNIT_CELSIUS    = 2'd1;
  localparam logic [1:0] UNIT_FAHRENHEIT = 2'd2;
  localparam logic [1:0] FACE_HAPPY      = 2'd1;
  localparam logic [1:0] FACE_SAD        = 2'd2;

  localparam logic [7:0] SEG_HI_HIGH  = 8'h67;
  localparam logic [7:0] SEG_HI_LOW   = 8'h40;
  localparam logic [7:0] SEG_LO_HIGH  = 8'hE0;
  localparam logic [7:0] SEG_LO_LOW   = 8'hC6;
  localparam logic [7:0] SEG_CELSIUS  = 8'hA0;
  localparam logic [7:0] SEG_FAHR     = 8'h60;
  localparam logic [7:0] SEG_BLE      = 8'h10;
  localparam logic [7:0] SEG_HAPPY    = 8'h05;
  localparam logic [7:0] SEG_SAD      = 8'h06;
  localparam logic [7:0] SEG_POINT    = 8'h08;
  localparam logic [7:0] SEG_ONE      = 8'h08;
  localparam logic [7:0] SEG_SIGN     = 8'h02;
  localparam logic [7:0] SEG_PCT      = 8'h08;
  localparam logic [7:0] SEG_BAT      = 8'h08;

endpackage

// ===== src/seven_segment_panel_composer.sv =====
// ----------------------------------------------------------------------------
// seven_segment_panel_composer
// Builds the six segment bytes of a small LCD panel from one panel word,
// with an XOR check and a changed flag against the last frame sent.
//
//   channel  direction  handshake            payload
//   in_      sink       in_valid/in_ready    big, unit, small, pct, ble, bat, face
//   out_     source     out_valid/out_ready  seg_byte0..5, frame_check, changed
//
// One word per cycle sustained while out_ready holds; each word is written into the
// queue register at the input accept and moves on to the output register from there.
// A two-word queue decouples classify from compose; in_ready drops only when
// it is full, so the input keeps flowing while a result waits.
// Synchronous reset clears the queue, the output valid and the stored frame.
// ----------------------------------------------------------------------------
module seven_segment_panel_composer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_big_value,
  input  logic [1:0]         in_temp_unit,
  input  logic signed [15:0] in_small_value,
  input  logic               in_percent_on,
  input  logic               in_ble_on,
  input  logic               in_battery_on,
  input  logic [1:0]         in_smiley_mode,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_seg_byte0,
  output logic [7:0]         out_seg_byte1,
  output logic [7:0]         out_seg_byte2,
  output logic [7:0]         out_seg_byte3,
  output logic [7:0]         out_seg_byte4,
  output logic [7:0]         out_seg_byte5,
  output logic [7:0]         out_frame_check,
  output logic               out_changed
);

  sspc_pkg::item_t front_item;
  sspc_pkg::item_t q_item;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;
  logic            push;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  sspc_front u_front (
    .big_value   (in_big_value),
    .temp_unit   (in_temp_unit),
    .small_value (in_small_value),
    .percent_on  (in_percent_on),
    .ble_on      (in_ble_on),
    .battery_on  (in_battery_on),
    .smiley_mode (in_smiley_mode),
    .item        (front_item)
  );

  sspc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_item),
    .not_empty (q_valid)
  );

  sspc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_seg_byte0   (out_seg_byte0),
    .out_seg_byte1   (out_seg_byte1),
    .out_seg_byte2   (out_seg_byte2),
    .out_seg_byte3   (out_seg_byte3),
    .out_seg_byte4   (out_seg_byte4),
    .out_seg_byte5   (out_seg_byte5),
    .out_frame_check (out_frame_check),
    .out_changed     (out_changed),
    .out_valid       (out_valid),
    .out_ready       (out_ready)
  );

endmodule

// ===== src/sspc_front.sv =====
// ----------------------------------------------------------------------------
// sspc_front
// Classifies one panel word: Hi/Lo limits, point or whole mode with rounding,
// sign and magnitude of both readings, and the icon byte.
// ----------------------------------------------------------------------------
module sspc_front (
  input  logic signed [15:0] big_value,
  input  logic [1:0]         temp_unit,
  input  logic signed [15:0] small_value,
  input  logic               percent_on,
  input  logic               ble_on,
  input  logic               battery_on,
  input  logic [1:0]         smiley_mode,
  output sspc_pkg::item_t    item
);

  logic [15:0] big_abs;
  logic [14:0] abs15;
  logic [30:0] prod;
  logic [10:0] quo;
  logic [14:0] rem;
  logic        round_up;
  logic        point;
  logic [15:0] small_abs;
  logic [7:0]  unit_seg;
  logic [7:0]  face_seg;

  assign big_abs  = big_value[15] ? (~$unsigned(big_value)) + 16'd1 : $unsigned(big_value);
  assign abs15    = big_abs[14:0];
  assign prod     = {16'd0, abs15} * {15'd0, sspc_pkg::DIV10_MUL};
  assign quo      = prod[29:19];
  assign rem      = abs15 - (({4'd0, quo} << 3) + ({4'd0, quo} << 1));
  assign round_up = rem[3:0] > 4'd5;
  assign point    = (big_value <= sspc_pkg::POINT_HI_LIM) &&
                    (big_value >= sspc_pkg::POINT_LO_LIM);

  assign small_abs = small_value[15] ? (~$unsigned(small_value)) + 16'd1
                                     : $unsigned(small_value);

  always_comb begin
    unique case (temp_unit)
      sspc_pkg::UNIT_CELSIUS:    unit_seg = sspc_pkg::SEG_CELSIUS;
      sspc_pkg::UNIT_FAHRENHEIT: unit_seg = sspc_pkg::SEG_FAHR;
      default:                   unit_seg = 8'h00;
    endcase
    unique case (smiley_mode)
      sspc_pkg::FACE_HAPPY: face_seg = sspc_pkg::SEG_HAPPY;
      sspc_pkg::FACE_SAD:   face_seg = sspc_pkg::SEG_SAD;
      default:              face_seg = 8'h00;
    endcase
  end

  always_comb begin
    item.big_hi    = big_value > sspc_pkg::BIG_HI_LIM;
    item.big_lo    = big_value < sspc_pkg::BIG_LO_LIM;
    item.big_neg   = big_value[15];
    item.big_point = point;
    item.big_mag   = point ? abs15[10:0] : quo + {10'd0, round_up};
    item.small_hi  = small_value > sspc_pkg::SMALL_HI_LIM;
    item.small_lo  = small_value < sspc_pkg::SMALL_LO_LIM;
    item.small_neg = small_value[15];
    item.small_mag = small_abs[6:0];
    item.pct       = percent_on;
    item.bat       = battery_on;
    item.byte2     = unit_seg | face_seg | (ble_on ? sspc_pkg::SEG_BLE : 8'h00);
  end

endmodule

// ===== src/sspc_fifo.sv =====
// ----------------------------------------------------------------------------
// sspc_fifo
// Two-word queue between the classify front and the compose back.
// ----------------------------------------------------------------------------
module sspc_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sspc_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output sspc_pkg::item_t pop_item,
  output logic            not_empty
);

  sspc_pkg::item_t mem_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      count_r,  count_nxt;

  assign full      = count_r == 2'd2;
  assign not_empty = count_r != 2'd0;
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== src/sspc_back.sv =====
// ----------------------------------------------------------------------------
// sspc_back
// Splits the magnitudes into digits, builds the six segment bytes, the XOR
// check and the changed flag, and holds the result word for the sink.
// ----------------------------------------------------------------------------
module sspc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  sspc_pkg::item_t q_item,
  output logic            q_pop,
  output logic [7:0]      out_seg_byte0,
  output logic [7:0]      out_seg_byte1,
  output logic [7:0]      out_seg_byte2,
  output logic [7:0]      out_seg_byte3,
  output logic [7:0]      out_seg_byte4,
  output logic [7:0]      out_seg_byte5,
  output logic [7:0]      out_frame_check,
  output logic            out_changed,
  output logic            out_valid,
  input  logic            out_ready
);

  function automatic logic [7:0] split_tens(input logic [6:0] v);
    logic [3:0] t;
    logic [6:0] u;
    t = 4'd0;
    u = v;
    for (int k = 1; k < 10; k++) begin
      if (v >= 7'(k * 10)) begin
        t = 4'(k);
        u = v - 7'(k * 10);
      end
    end
    return {t, u[3:0]};
  endfunction

  function automatic logic [10:0] split_hundreds(input logic [9:0] v);
    logic [3:0] h;
    logic [9:0] r;
    h = 4'd0;
    r = v;
    for (int k = 1; k < 10; k++) begin
      if (v >= 10'(k * 100)) begin
        h = 4'(k);
        r = v - 10'(k * 100);
      end
    end
    return {h, r[6:0]};
  endfunction

  logic        thou;
  logic [9:0]  below_thou;
  logic [10:0] hund_split;
  logic [7:0]  big_tu;
  logic [7:0]  small_tu;
  logic [7:0]  b [6];
  logic [47:0] frame;
  logic [47:0] last_frame_r;
  logic        valid_r;
  logic [7:0]  byte_r [6];
  logic [7:0]  check_r;
  logic        changed_r;

  assign q_pop = q_valid && (!valid_r || out_ready);

  always_comb begin
    thou       = q_item.big_mag > 11'd999;
    below_thou = thou ? 10'(q_item.big_mag - 11'd1000) : q_item.big_mag[9:0];
    hund_split = split_hundreds(below_thou);
    big_tu     = split_tens(hund_split[6:0]);
    small_tu   = split_tens(q_item.small_mag);

    b[2] = q_item.byte2;

    if (q_item.big_hi) begin
      b[5] = sspc_pkg::SEG_HI_HIGH;
      b[4] = sspc_pkg::SEG_HI_LOW;
      b[3] = 8'h00;
    end else if (q_item.big_lo) begin
      b[5] = sspc_pkg::SEG_LO_HIGH;
      b[4] = sspc_pkg::SEG_LO_LOW;
      b[3] = 8'h00;
    end else begin
      b[5] = (q_item.big_neg ? sspc_pkg::SEG_SIGN : 8'h00) |
             (thou ? sspc_pkg::SEG_ONE : 8'h00) |
             ((q_item.big_mag > 11'd99) ? sspc_pkg::SEG_DIGIT[hund_split[10:7]] : 8'h00);
      b[4] = (q_item.big_point ? sspc_pkg::SEG_POINT : 8'h00) |
             sspc_pkg::SEG_DIGIT[big_tu[7:4]];
      b[3] = sspc_pkg::SEG_DIGIT[big_tu[3:0]];
    end

    b[0] = q_item.pct ? sspc_pkg::SEG_PCT : 8'h00;
    b[1] = q_item.bat ? sspc_pkg::SEG_BAT : 8'h00;
    if (q_item.small_hi) begin
      b[0] = b[0] | sspc_pkg::SEG_HI_LOW;
      b[1] = b[1] | sspc_pkg::SEG_HI_HIGH;
    end else if (q_item.small_lo) begin
      b[0] = b[0] | sspc_pkg::SEG_LO_LOW;
      b[1] = b[1] | sspc_pkg::SEG_LO_HIGH;
    end else begin
      b[1] = b[1] | (q_item.small_neg ? sspc_pkg::SEG_SIGN : 8'h00) |
             ((q_item.small_mag > 7'd9) ? sspc_pkg::SEG_DIGIT[small_tu[7:4]] : 8'h00);
      b[0] = b[0] | sspc_pkg::SEG_DIGIT[small_tu[3:0]];
    end

    frame = {b[5], b[4], b[3], b[2], b[1], b[0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      last_frame_r <= 48'd0;
    end else begin
      if (q_pop) begin
        valid_r      <= 1'b1;
        last_frame_r <= frame;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int k = 0; k < 6; k++) begin
        byte_r[k] <= b[k];
      end
      check_r   <= b[0] ^ b[1] ^ b[2] ^ b[3] ^ b[4] ^ b[5];
      changed_r <= frame != last_frame_r;
    end
  end

  assign out_seg_byte0   = byte_r[0];
  assign out_seg_byte1   = byte_r[1];
  assign out_seg_byte2   = byte_r[2];
  assign out_seg_byte3   = byte_r[3];
  assign out_seg_byte4   = byte_r[4];
  assign out_seg_byte5   = byte_r[5];
  assign out_frame_check = check_r;
  assign out_changed     = changed_r;
  assign out_valid       = valid_r;

endmodule

// ===== src/sspc_checker.sv =====
// ----------------------------------------------------------------------------
// sspc_checker
// Port-level checks of the panel composer, bound to the top level.
// ----------------------------------------------------------------------------
module sspc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic signed [15:0] in_big_value,
  input logic               out_valid,
  input logic               out_ready,
  input logic [7:0]         out_seg_byte0,
  input logic [7:0]         out_seg_byte1,
  input logic [7:0]         out_seg_byte2,
  input logic [7:0]         out_seg_byte3,
  input logic [7:0]         out_seg_byte4,
  input logic [7:0]         out_seg_byte5,
  input logic [7:0]         out_frame_check,
  input logic               out_changed
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_big_value))
    else $error("input word dropped or changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_seg_byte0) &&
      $stable(out_seg_byte3) && $stable(out_seg_byte5) &&
      $stable(out_frame_check) && $stable(out_changed))
    else $error("result word changed while stalled");

  a_check_xor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frame_check == (out_seg_byte0 ^ out_seg_byte1 ^ out_seg_byte2 ^
                                      out_seg_byte3 ^ out_seg_byte4 ^ out_seg_byte5))
    else $error("frame check does not match segment bytes");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind seven_segment_panel_composer sspc_checker u_sspc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_big_value    (in_big_value),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_seg_byte0   (out_seg_byte0),
  .out_seg_byte1   (out_seg_byte1),
  .out_seg_byte2   (out_seg_byte2),
  .out_seg_byte3   (out_seg_byte3),
  .out_seg_byte4   (out_seg_byte4),
  .out_seg_byte5   (out_seg_byte5),
  .out_frame_check (out_frame_check),
  .out_changed     (out_changed)
);
